// ===== hdl/pcfwl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcfwl_pkg - shared types and constants of the per-client window limiter
// Table entry layout, elapsed-time unit result and register indexes.
// ----------------------------------------------------------------------------
package pcfwl_pkg;

  localparam int ADDR_W     = 32;
  localparam int TIME_W     = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int COUNT_W    = 17;

  localparam logic [COUNT_W-1:0]    COUNT_MAX = '1;
  localparam logic [CFG_IDX_W-1:0]  REG_REQ_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_WIN_LEN   = 2'd1;
  localparam logic [CFG_DATA_W-1:0] RESET_REQ_LIMIT = 16'd100;
  localparam logic [CFG_DATA_W-1:0] RESET_WIN_LEN   = 16'd60;

  // one tracked client
  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  client;
    logic [TIME_W-1:0]  window_start;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // result of the shared elapsed-time unit
  typedef struct packed {
    logic [TIME_W-1:0] elapsed;
    logic              expired;   // elapsed > window
    logic              below;     // elapsed < window
  } elapsed_t;

endpackage : pcfwl_pkg
`default_nettype wire

// ===== hdl/pcfwl_elapsed.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcfwl_elapsed - shared elapsed-time unit
// Subtracts a window start from the current time (mod 2^32) and compares.
// ----------------------------------------------------------------------------
module pcfwl_elapsed (
  input  wire logic [pcfwl_pkg::TIME_W-1:0]     now_time,
  input  wire logic [pcfwl_pkg::TIME_W-1:0]     start_time,
  input  wire logic [pcfwl_pkg::CFG_DATA_W-1:0] window,
  output pcfwl_pkg::elapsed_t                   result
);
  import pcfwl_pkg::*;

  logic [TIME_W-1:0] diff;
  logic [TIME_W-1:0] window_ext;

  assign diff       = now_time - start_time;
  assign window_ext = {{(TIME_W-CFG_DATA_W){1'b0}}, window};

  always_comb begin
    result.elapsed = diff;
    result.expired = diff > window_ext;
    // not above and not equal means below
    result.below   = !result.expired && (diff != window_ext);
  end

endmodule : pcfwl_elapsed
`default_nettype wire

// ===== hdl/pcfwl_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcfwl_table - client table storage
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module pcfwl_table #(
  parameter int DEPTH = 64,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [IDX_W-1:0]  waddr,
  input  wire pcfwl_pkg::entry_t wdata,
  input  wire logic [IDX_W-1:0]  raddr,
  output pcfwl_pkg::entry_t      rdata
);
  import pcfwl_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : pcfwl_table
`default_nettype wire

// ===== hdl/per_client_fixed_window_limiter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// per_client_fixed_window_limiter - fixed-window request limiter per client
// Tracks up to TABLE_ENTRIES clients; each request sweeps the table, frees
// expired entries, finds or allocates the client (if an entry is free) and counts it.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction | handshake
//  --------+-------------------------------------------+-----------+-----------
//  in      | client_address, now_seconds               | in        | in_valid/in_ready
//  out     | denied, retry_after, table_full           | out       | out_valid/out_ready
//  cfg     | cfg_index, cfg_data                       | in        | cfg_write, no wait
//
//  Scan: the table is read through the single read port of the table memory,
//    one entry per cycle; a new transaction is accepted only after the
//    previous one has loaded its result register.
//  Reset: after rst the table is cleared one entry per cycle, with in_ready
//    low; config writes are taken meanwhile.
//  Stalls: the final result load waits for the output register, and the next
//    transaction is not accepted until that load; a pending result blocks it.
// ----------------------------------------------------------------------------
module per_client_fixed_window_limiter #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [pcfwl_pkg::ADDR_W-1:0]        client_address,
  input  wire logic [pcfwl_pkg::TIME_W-1:0]        now_seconds,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     denied,
  output logic [pcfwl_pkg::CFG_DATA_W-1:0]         retry_after,
  output logic                                     table_full,
  // config write port
  input  wire logic                                cfg_write,
  input  wire logic [pcfwl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pcfwl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pcfwl_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] N_ENTRIES = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t state;

  // config registers
  logic [CFG_DATA_W-1:0] req_limit;
  logic [CFG_DATA_W-1:0] win_len;

  // request latch
  logic [ADDR_W-1:0] req_addr;
  logic [TIME_W-1:0] req_now;

  // scan bookkeeping
  logic [CNT_W-1:0] iss;        // next entry to read; also clear pointer
  logic             chk_valid;  // read data in flight belongs to chk_idx
  logic [IDX_W-1:0] chk_idx;
  logic             found_hit;
  logic [IDX_W-1:0] hit_idx;
  logic [TIME_W-1:0]  hit_start;
  logic [COUNT_W-1:0] hit_count;
  logic             found_free;
  logic [IDX_W-1:0] free_idx;

  // result staging
  logic [COUNT_W-1:0]    new_count;
  logic [CFG_DATA_W-1:0] retry_val;
  logic                  res_full;
  logic                  load_result;  // result register takes the staged result

  // table ports
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  entry_t           tbl_wdata;
  entry_t           tbl_rdata;

  // shared elapsed unit
  logic [TIME_W-1:0] eu_start;
  elapsed_t          eu;

  logic scan_expired;
  logic scan_live;

  assign in_ready    = (state == ST_IDLE);
  assign load_result = (state == ST_RESULT) && (!out_valid || out_ready);

  pcfwl_table #(
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (iss[IDX_W-1:0]),
    .rdata (tbl_rdata)
  );

  // during the scan the unit checks the entry just read, during update the hit
  assign eu_start = (state == ST_SCAN) ? tbl_rdata.window_start : hit_start;

  pcfwl_elapsed u_elapsed (
    .now_time   (req_now),
    .start_time (eu_start),
    .window     (win_len),
    .result     (eu)
  );

  assign scan_expired = chk_valid && tbl_rdata.valid && eu.expired;
  assign scan_live    = tbl_rdata.valid && !eu.expired;

  // table write mux: clear pass, expiry in scan, update of the chosen entry
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = chk_idx;
    tbl_wdata = tbl_rdata;
    tbl_wdata.valid = 1'b0;
    case (state)
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = iss[IDX_W-1:0];
      end
      ST_SCAN: begin
        tbl_we = scan_expired;
      end
      ST_UPDATE: begin
        tbl_wdata.valid  = 1'b1;
        tbl_wdata.client = req_addr;
        if (found_hit) begin
          tbl_we    = 1'b1;
          tbl_waddr = hit_idx;
          if (eu.below) begin
            tbl_wdata.window_start = hit_start;
            tbl_wdata.count = (hit_count != COUNT_MAX) ? hit_count + 1'b1 : hit_count;
          end else begin
            tbl_wdata.window_start = req_now;
            tbl_wdata.count = COUNT_W'(1);
          end
        end else begin
          tbl_we    = found_free;
          tbl_waddr = free_idx;
          tbl_wdata.window_start = req_now;
          tbl_wdata.count = COUNT_W'(1);
        end
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      req_limit <= RESET_REQ_LIMIT;
      win_len   <= RESET_WIN_LEN;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_REQ_LIMIT: req_limit <= cfg_data;
        REG_WIN_LEN:   win_len   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      iss       <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (iss[IDX_W-1:0] == LAST_IDX) begin
            iss   <= '0;
            state <= ST_IDLE;
          end else begin
            iss <= iss + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            iss        <= '0;
            chk_valid  <= 1'b0;
            found_hit  <= 1'b0;
            found_free <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // read issue, one entry per cycle
          chk_valid <= (iss < N_ENTRIES);
          chk_idx   <= iss[IDX_W-1:0];
          if (iss < N_ENTRIES) begin
            iss <= iss + 1'b1;
          end
          // check of the entry read last cycle
          if (chk_valid) begin
            if (scan_live && !found_hit && tbl_rdata.client == req_addr) begin
              found_hit <= 1'b1;
              hit_idx   <= chk_idx;
              hit_start <= tbl_rdata.window_start;
              hit_count <= tbl_rdata.count;
            end
            if (!scan_live && !found_free) begin
              found_free <= 1'b1;
              free_idx   <= chk_idx;
            end
            if (chk_idx == LAST_IDX) begin
              chk_valid <= 1'b0;
              iss       <= '0;
              state     <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          res_full  <= !found_hit && !found_free;
          new_count <= tbl_wdata.count;
          // restart or allocation means zero elapsed
          retry_val <= (found_hit && eu.below)
                       ? win_len - eu.elapsed[CFG_DATA_W-1:0]
                       : win_len;
          state     <= ST_RESULT;
        end
        ST_RESULT: begin
          if (load_result) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request latch and output payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req_addr <= client_address;
      req_now  <= now_seconds;
    end
    if (load_result) begin
      denied      <= !res_full && (new_count > {1'b0, req_limit});
      retry_after <= (!res_full && (new_count > {1'b0, req_limit}))
                     ? retry_val : '0;
      table_full  <= res_full;
    end
  end

  // checks
  a_deny_not_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(denied && table_full))
    else $error("denied and table_full both set");

  a_retry_only_denied: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !denied) |-> (retry_after == '0))
    else $error("retry_after nonzero on a passed transaction");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_SCAN))
    else $error("accepted transaction did not start a scan");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_RESULT) |-> !tbl_we)
    else $error("table written outside clear, scan or update");

endmodule : per_client_fixed_window_limiter
`default_nettype wire
